FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the gate block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every edge outside reset.
`define SDG_ASSERT_IMP(lbl, clk_s, rst_n, a, c) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SDG_ASSERT_NXT(lbl, clk_s, rst_n, a, c) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

FILE: hw/rtl/sdg_pkg.sv
package sdg_pkg;
	localparam int SHOOT_ARM_FRAMES = 3;
	localparam int DRIBBLE_ARM_FRAMES = 1;
	localparam int CORDIC_STEPS = 16;
	localparam int CW = 40;
	localparam int ZW = 34;
	localparam int CST = CORDIC_STEPS + 1;
	// Flag queue between front and back, its pointer and its fill count widths.
	localparam int QDEPTH = CST + 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int SW = $clog2(QDEPTH + 1);
	localparam logic [4:0] CFG_ENTER = 5'd0;
	localparam logic [4:0] CFG_EXIT = 5'd1;
	localparam logic [15:0] ANG_25 = 16'd4551;
	localparam logic [15:0] ANG_30 = 16'd5461;
	localparam logic [15:0] ANG_35 = 16'd6371;
	localparam logic [15:0] ANG_45 = 16'd8192;
	localparam logic [15:0] ANG_55 = 16'd10012;
	localparam logic [16:0] BEAR_MAX = 17'd32768;

	// Decision flags for one frame, handed from front to back.
	typedef struct packed {
		logic clear;
		logic shoot_enter;
		logic shoot_hold;
		logic drib_enter;
		logic drib_hold;
	} flags_t;

	typedef struct packed {
		logic shoot_on;
		logic dribble_on;
		logic [1:0] shoot_progress;
	} result_t;

	function automatic logic signed [ZW-1:0] arc(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd536870912;  1: r = 34'sd316933406;
			2: r = 34'sd167458907;  3: r = 34'sd85004756;
			4: r = 34'sd42667331;   5: r = 34'sd21354465;
			6: r = 34'sd10679838;   7: r = 34'sd5340245;
			8: r = 34'sd2670163;    9: r = 34'sd1335087;
			10: r = 34'sd667544;    11: r = 34'sd333772;
			12: r = 34'sd166886;    13: r = 34'sd83443;
			14: r = 34'sd41722;     15: r = 34'sd20861;
			16: r = 34'sd10430;     17: r = 34'sd5215;
			18: r = 34'sd2608;      default: r = 34'sd1304;
		endcase
		return r;
	endfunction
endpackage

FILE: hw/rtl/sdg_cordic.sv
module sdg_cordic (
	input  logic clk,
	input  logic signed [15:0] vx,
	input  logic signed [15:0] vy,
	output logic [16:0] ang_mag
);
	import sdg_pkg::*;
	logic signed [CW-1:0] x_s [CST];
	logic signed [CW-1:0] y_s [CST];
	logic signed [ZW-1:0] z_s [CST];
	logic xneg_s [CST];
	logic zero_s [CST];
	logic signed [ZW-1:0] zc;
	logic signed [ZW-1:0] af;
	logic [16:0] ang_q;

	always_ff @(posedge clk) begin
		x_s[0] <= {{(CW-32){1'b0}}, (vx < 0 ? -{vx[15], vx} : {vx[15], vx}), 15'd0} <<< 1;
		y_s[0] <= {{(CW-32){1'b0}}, (vy < 0 ? -{vy[15], vy} : {vy[15], vy}), 15'd0} <<< 1;
		z_s[0] <= '0;
		xneg_s[0] <= vx[15];
		zero_s[0] <= (vx == 0) && (vy == 0);
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + arc(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - arc(i);
			end
			xneg_s[i+1] <= xneg_s[i];
			zero_s[i+1] <= zero_s[i];
		end
		ang_q <= af[32:16];
	end

	always_comb begin
		zc = z_s[CST-1];
		if (zero_s[CST-1]) zc = '0;
		else if (zc < 0) zc = '0;
		else if (zc > 34'sd1073741824) zc = 34'sd1073741824;
		if (xneg_s[CST-1]) zc = 34'sd2147483648 - zc;
		af = zc + 34'sd32768;
	end
	assign ang_mag = ang_q;
endmodule

FILE: hw/rtl/sdg_front.sv
module sdg_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic clear,
	input  logic signed [14:0] ball_rel_x,
	input  logic signed [14:0] ball_rel_y,
	input  logic signed [13:0] ball_field_x,
	input  logic signed [13:0] ball_field_y,
	input  logic signed [13:0] robot_field_x,
	input  logic signed [13:0] robot_field_y,
	input  logic signed [15:0] robot_heading,
	input  logic [15:0] ball_age_ms,
	input  logic [14:0] shot_opening,
	input  logic can_score_now,
	input  logic [14:0] open_enter,
	input  logic [14:0] open_exit,
	output logic out_valid,
	output sdg_pkg::flags_t out_flags
);
	import sdg_pkg::*;
	localparam int DL = CST + 1;
	logic v_s [DL];
	logic clr_s [DL];
	logic signed [15:0] head_s [DL];
	logic fresh_s [DL], age_de_s [DL], age_dh_s [DL];
	logic le_s [DL], lx_s [DL];
	logic d380_s [DL], d460_s [DL], d450_s [DL], d600_s [DL];
	logic g30_s [DL], g32_s [DL];
	logic [16:0] ab, gb;
	logic [29:0] d2, g2;
	logic signed [14:0] gx;
	logic signed [15:0] diff;
	logic [16:0] dmag, gbs;

	assign d2 = 30'(ball_rel_x * ball_rel_x) + 30'(ball_rel_y * ball_rel_y);
	assign gx = 15'sd4500 - 15'(ball_field_x);
	assign g2 = 30'(gx * gx) + 30'(ball_field_y * ball_field_y);

	sdg_cordic u_ball (.clk, .vx(16'(ball_rel_x)), .vy(16'(ball_rel_y)), .ang_mag(ab));
	sdg_cordic u_goal (.clk, .vx(16'sd4500 - 16'(robot_field_x)),
		.vy(-16'(robot_field_y)), .ang_mag(gb));

	logic ny_s [DL];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) v_s[i] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int i = 1; i < DL; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		clr_s[0] <= clear;
		head_s[0] <= robot_heading;
		ny_s[0] <= (robot_field_y > 0);
		fresh_s[0] <= ball_age_ms <= 16'd600;
		age_de_s[0] <= ball_age_ms <= 16'd1500;
		age_dh_s[0] <= ball_age_ms <= 16'd2500;
		le_s[0] <= (shot_opening >= open_enter) || can_score_now;
		lx_s[0] <= (shot_opening >= open_exit) || can_score_now;
		d380_s[0] <= d2 <= 30'd144400;
		d460_s[0] <= d2 <= 30'd211600;
		d450_s[0] <= d2 <= 30'd202500;
		d600_s[0] <= d2 <= 30'd360000;
		g30_s[0] <= g2 <= 30'd9000000;
		g32_s[0] <= g2 <= 30'd10240000;
		for (int i = 1; i < DL; i++) begin
			clr_s[i] <= clr_s[i-1]; head_s[i] <= head_s[i-1]; ny_s[i] <= ny_s[i-1];
			fresh_s[i] <= fresh_s[i-1]; age_de_s[i] <= age_de_s[i-1];
			age_dh_s[i] <= age_dh_s[i-1]; le_s[i] <= le_s[i-1]; lx_s[i] <= lx_s[i-1];
			d380_s[i] <= d380_s[i-1]; d460_s[i] <= d460_s[i-1];
			d450_s[i] <= d450_s[i-1]; d600_s[i] <= d600_s[i-1];
			g30_s[i] <= g30_s[i-1]; g32_s[i] <= g32_s[i-1];
		end
	end

	// Goal bearing is negative when the robot sits above the x axis.
	assign gbs = ny_s[DL-1] ? (17'd0 - gb) : gb;
	assign diff = head_s[DL-1] - gbs[15:0];
	assign dmag = diff[15] ? (17'd0 - {diff[15], diff}) : {1'b0, diff};

	always_comb begin
		out_valid = v_s[DL-1];
		out_flags.clear = clr_s[DL-1];
		out_flags.shoot_enter = fresh_s[DL-1] && d380_s[DL-1] && (ab <= {1'b0, ANG_25})
			&& le_s[DL-1] && g30_s[DL-1] && (dmag <= {1'b0, ANG_30});
		out_flags.shoot_hold = fresh_s[DL-1] && d460_s[DL-1] && (ab <= {1'b0, ANG_35})
			&& lx_s[DL-1] && g32_s[DL-1] && (dmag <= {1'b0, ANG_45});
		out_flags.drib_enter = age_de_s[DL-1] && d450_s[DL-1] && (ab <= {1'b0, ANG_35});
		out_flags.drib_hold = age_dh_s[DL-1] && d600_s[DL-1] && (ab <= {1'b0, ANG_55});
	end
endmodule

FILE: hw/rtl/sdg_back.sv
module sdg_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sdg_pkg::flags_t in_flags,
	output logic out_valid,
	input  logic out_ready,
	output sdg_pkg::result_t out_res,
	output logic [sdg_pkg::SW-1:0] level
);
	import sdg_pkg::*;
	localparam int SW_LEN = SW;
	localparam int DEPTH = QDEPTH;
	localparam int AW = QAW;
	flags_t fifo_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [SW_LEN-1:0] cnt_q;
	logic sg_q, dg_q;
	logic [1:0] sr_q, dr_q;
	logic ov_q;
	result_t res_q;
	logic pop, take;
	flags_t f;
	logic nsg, ndg;
	logic [1:0] nsr, ndr;

	assign take = !ov_q || out_ready;
	assign pop = (cnt_q != '0) && take;
	assign f = fifo_q[rp_q];
	assign level = cnt_q;

	always_comb begin
		nsg = sg_q; nsr = sr_q; ndg = dg_q; ndr = dr_q;
		if (f.clear) begin
			nsg = 1'b0; nsr = '0; ndg = 1'b0; ndr = '0;
		end else begin
			if (!sg_q) begin
				nsr = f.shoot_enter ? ((sr_q == 2'd3) ? 2'd3 : sr_q + 2'd1) : 2'd0;
				if (nsr >= 2'(SHOOT_ARM_FRAMES)) nsg = 1'b1;
			end else if (!f.shoot_hold) begin
				nsg = 1'b0; nsr = '0;
			end
			if (!dg_q) begin
				ndr = f.drib_enter ? ((dr_q == 2'd3) ? 2'd3 : dr_q + 2'd1) : 2'd0;
				if (ndr >= 2'(DRIBBLE_ARM_FRAMES)) ndg = 1'b1;
			end else if (!f.drib_hold) begin
				ndg = 1'b0; ndr = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
			sg_q <= 1'b0; dg_q <= 1'b0; sr_q <= '0; dr_q <= '0;
		end else begin
			if (in_valid) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
				sg_q <= nsg; dg_q <= ndg; sr_q <= nsr; dr_q <= ndr;
			end
			cnt_q <= cnt_q + SW_LEN'(in_valid) - SW_LEN'(pop);
			if (pop) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) fifo_q[wp_q] <= in_flags;
		if (pop) begin
			res_q.shoot_on <= nsg;
			res_q.dribble_on <= ndg;
			res_q.shoot_progress <= nsg ? 2'(SHOOT_ARM_FRAMES) : nsr;
		end
	end

	assign out_valid = ov_q;
	assign out_res = res_q;
endmodule

FILE: hw/rtl/shoot_dribble_hysteresis_gate_top.sv
// Path from input request to result: input stage, 16 CORDIC iterations,
// angle rounding, queue write and output register.
// Throughput: one request per cycle; a flag queue of 21 entries absorbs downstream stalls.
// s_tready drops once the queue plus the requests in flight could overrun it.
// Reset: arst_n asynchronous active low clears gates, runs, registers and queue pointers.
`include "assert_macros.svh"
module shoot_dribble_hysteresis_gate_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata from bit 0: clear, ball_rel_x, ball_rel_y, ball_field_x, ball_field_y,
	// robot_field_x, robot_field_y, robot_heading, ball_age_ms, shot_opening,
	// can_score_now, then zero fill
	input  logic [135:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata from bit 0: shoot_on, dribble_on, shoot_progress, then zero fill
	output logic [7:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [4:0] cfg_index,
	input  logic [14:0] cfg_data
);
	import sdg_pkg::*;
	// The queue has room for every request that the geometry pipe still carries.
	localparam int DEPTH = QDEPTH;
	logic [14:0] open_enter_q, open_exit_q;
	logic acc, fv;
	flags_t ff;
	result_t res;
	logic [SW-1:0] level;
	logic [SW-1:0] inflight_q;

	assign acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_enter_q <= '0; open_exit_q <= '0; inflight_q <= '0;
		end else begin
			if (cfg_valid && cfg_index == CFG_ENTER) open_enter_q <= cfg_data;
			if (cfg_valid && cfg_index == CFG_EXIT) open_exit_q <= cfg_data;
			inflight_q <= inflight_q + SW'(acc) - SW'(fv);
		end
	end
	// Requests in the pipe plus queued flags must fit in the queue.
	assign s_tready = (32'(inflight_q) + 32'(level)) < (DEPTH - 1);

	sdg_front u_front (
		.clk, .arst_n, .in_valid(acc),
		.clear(s_tdata[0]),
		.ball_rel_x(s_tdata[15:1]), .ball_rel_y(s_tdata[30:16]),
		.ball_field_x(s_tdata[44:31]), .ball_field_y(s_tdata[58:45]),
		.robot_field_x(s_tdata[72:59]), .robot_field_y(s_tdata[86:73]),
		.robot_heading(s_tdata[102:87]), .ball_age_ms(s_tdata[118:103]),
		.shot_opening(s_tdata[133:119]), .can_score_now(s_tdata[134]),
		.open_enter(open_enter_q), .open_exit(open_exit_q),
		.out_valid(fv), .out_flags(ff)
	);
	sdg_back u_back (
		.clk, .arst_n, .in_valid(fv), .in_flags(ff),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res), .level(level)
	);
	assign m_tdata = {4'd0, res.shoot_progress, res.dribble_on, res.shoot_on};

	`SDG_ASSERT_IMP(a_no_overrun, clk, arst_n, 1'b1, (32'(inflight_q) + 32'(level)) <= DEPTH)
	`SDG_ASSERT_IMP(a_progress_full, clk, arst_n, m_tvalid && res.shoot_on,
		res.shoot_progress == 2'(SHOOT_ARM_FRAMES))
	`SDG_ASSERT_NXT(a_hold_result, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(res))
endmodule

FILE: tb/shoot_dribble_hysteresis_gate_top_tb.sv
`timescale 1ns / 1ps

module shoot_dribble_hysteresis_gate_top_tb;
	import sdg_pkg::*;

	localparam int GOAL_X = 4500;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 30;
	localparam logic [4:0] CFG_UNUSED = 5'd9;

	typedef struct {
		logic clear;
		logic signed [14:0] rel_x;
		logic signed [14:0] rel_y;
		logic signed [13:0] ball_x;
		logic signed [13:0] ball_y;
		logic signed [13:0] robot_x;
		logic signed [13:0] robot_y;
		logic signed [15:0] heading;
		logic [15:0] age_ms;
		logic [14:0] opening;
		logic can_score;
	} frame_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [135:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [4:0] cfg_index;
	logic [14:0] cfg_data;

	// Predictor state: both gates, both runs and the two opening thresholds.
	logic [14:0] open_enter_thr, open_exit_thr;
	logic shoot_armed, dribble_armed;
	logic [1:0] shoot_streak, dribble_streak;

	result_t gate_results_due[$];
	int send_idle_pct, recv_idle_pct;
	int mismatches, stall_cycles;

	// Arc tangents of 2^-i in units of pi/2^31.
	longint atan_steps[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304};

	shoot_dribble_hysteresis_gate_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// First-quadrant angle of a vector by shift-and-add rotation, pi/2^31 units.
	function automatic longint quadrant_angle(longint ax, longint ay);
		longint x, y, z, xs, ys;
		x = ax * 65536;
		y = ay * 65536;
		z = 0;
		if (ax == 0 && ay == 0)
			return 0;
		for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += atan_steps[i];
			end else begin
				x -= ys;
				y += xs;
				z -= atan_steps[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > (64'sd1 <<< 30))
			z = 64'sd1 <<< 30;
		return z;
	endfunction

	// Signed bearing of (x, y) in binary angle units, range -32768..32768.
	function automatic longint bearing_of(longint x, longint y);
		longint a, r;
		a = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
		if (x < 0)
			a = (64'sd1 <<< 31) - a;
		r = (a + 32768) >>> 16;
		return y < 0 ? -r : r;
	endfunction

	// One hysteresis gate: count a streak to arm, drop on the first failed hold.
	function automatic void step_gate(ref logic armed, ref logic [1:0] streak,
			input logic enter, input logic hold, input int frames);
		if (!armed) begin
			if (enter)
				streak = (streak < 2'd3) ? streak + 2'd1 : 2'd3;
			else
				streak = 2'd0;
			if (streak >= frames)
				armed = 1'b1;
		end else if (!hold) begin
			armed = 1'b0;
			streak = 2'd0;
		end
	endfunction

	function automatic result_t predict_gates(frame_t f);
		result_t r;
		longint d2, g2, gx, abear, goal_bear, align;
		logic signed [15:0] diff16;
		logic fresh, s_enter, s_hold, d_enter, d_hold;
		if (f.clear) begin
			shoot_armed = 1'b0;
			dribble_armed = 1'b0;
			shoot_streak = 2'd0;
			dribble_streak = 2'd0;
			return '0;
		end
		d2 = longint'(f.rel_x) * f.rel_x + longint'(f.rel_y) * f.rel_y;
		abear = bearing_of(f.rel_x, f.rel_y);
		if (abear < 0)
			abear = -abear;
		gx = GOAL_X - longint'(f.ball_x);
		g2 = gx * gx + longint'(f.ball_y) * f.ball_y;
		goal_bear = bearing_of(GOAL_X - longint'(f.robot_x), -longint'(f.robot_y));
		diff16 = 16'(longint'(f.heading) - goal_bear);
		align = diff16;
		if (align < 0)
			align = -align;
		fresh = f.age_ms <= 600;
		s_enter = fresh && d2 <= 380 * 380 && abear <= ANG_25
			&& (f.opening >= open_enter_thr || f.can_score)
			&& g2 <= 3000 * 3000 && align <= ANG_30;
		s_hold = fresh && d2 <= 460 * 460 && abear <= ANG_35
			&& (f.opening >= open_exit_thr || f.can_score)
			&& g2 <= 3200 * 3200 && align <= ANG_45;
		step_gate(shoot_armed, shoot_streak, s_enter, s_hold, SHOOT_ARM_FRAMES);
		d_enter = f.age_ms <= 1500 && d2 <= 450 * 450 && abear <= ANG_35;
		d_hold = f.age_ms <= 2500 && d2 <= 600 * 600 && abear <= ANG_55;
		step_gate(dribble_armed, dribble_streak, d_enter, d_hold, DRIBBLE_ARM_FRAMES);
		r.shoot_on = shoot_armed;
		r.dribble_on = dribble_armed;
		r.shoot_progress = shoot_armed ? 2'(SHOOT_ARM_FRAMES) :
			(shoot_streak < SHOOT_ARM_FRAMES ? shoot_streak : 2'(SHOOT_ARM_FRAMES));
		return r;
	endfunction

	// Sends one frame, idling beforehand at the current sender rate.
	task automatic send_frame(frame_t f);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'd0, f.can_score, f.opening, f.age_ms, f.heading, f.robot_y,
			f.robot_x, f.ball_y, f.ball_x, f.rel_y, f.rel_x, f.clear};
		do @(posedge clk); while (!s_tready);
		gate_results_due.push_back(predict_gates(f));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (gate_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [4:0] idx, logic [14:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ENTER)
			open_enter_thr = val;
		else if (idx == CFG_EXIT)
			open_exit_thr = val;
	endtask

	// A frame that meets every shoot and dribble enter condition.
	function automatic frame_t ideal_frame();
		frame_t f;
		f.clear = 1'b0;
		f.rel_x = 15'sd200;
		f.rel_y = 15'sd0;
		f.ball_x = 14'sd3200;
		f.ball_y = 14'sd0;
		f.robot_x = 14'sd3000;
		f.robot_y = 14'sd0;
		f.heading = 16'sd0;
		f.age_ms = 16'd0;
		f.opening = 15'h7FFF;
		f.can_score = 1'b1;
		return f;
	endfunction

	function automatic frame_t raw_frame();
		frame_t f;
		f.clear = 1'b0;
		f.rel_x = 15'($urandom);
		f.rel_y = 15'($urandom);
		f.ball_x = 14'($urandom);
		f.ball_y = 14'($urandom);
		f.robot_x = 14'($urandom);
		f.robot_y = 14'($urandom);
		f.heading = 16'($urandom);
		f.age_ms = 16'($urandom);
		f.opening = 15'($urandom);
		f.can_score = 1'($urandom);
		return f;
	endfunction

	// Mostly plausible play near the goal, so that streaks build and gates
	// arm and drop; the rest is full-range noise and occasional clears.
	function automatic frame_t play_frame();
		frame_t f;
		int px, py, rx, ry, pick;
		longint aim;
		pick = $urandom_range(99);
		if (pick < 4) begin
			f = raw_frame();
			f.clear = 1'b1;
			return f;
		end
		if (pick < 22)
			return raw_frame();
		px = $urandom_range(4300, 1300);
		py = int'($urandom_range(3000)) - 1500;
		rx = int'($urandom_range(700)) - 100;
		ry = int'($urandom_range(800)) - 400;
		aim = bearing_of(GOAL_X - px, -py);
		f.clear = 1'b0;
		f.rel_x = 15'(rx);
		f.rel_y = 15'(ry);
		f.robot_x = 14'(px);
		f.robot_y = 14'(py);
		f.ball_x = 14'(px + rx);
		f.ball_y = 14'(py + ry);
		f.heading = 16'(aim + int'($urandom_range(16000)) - 8000);
		f.age_ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2800));
		f.opening = 15'($urandom);
		f.can_score = ($urandom_range(3) == 0);
		return f;
	endfunction

	task automatic test_field_extremes();
		frame_t f;
		f = ideal_frame();
		f.rel_x = 15'sd0;
		f.rel_y = 15'sd0;
		send_frame(f);  // zero-length ball vector
		f.rel_x = -15'sd300;
		send_frame(f);  // ball straight behind
		f = raw_frame();
		{f.rel_x, f.rel_y, f.ball_x, f.ball_y, f.robot_x, f.robot_y, f.heading} = '1;
		{f.age_ms, f.opening, f.can_score} = '1;
		send_frame(f);
		f.rel_x = 15'h4000; f.rel_y = 15'h4000; f.ball_x = 14'h2000; f.ball_y = 14'h2000;
		f.robot_x = 14'h2000; f.robot_y = 14'h2000; f.heading = 16'h8000;
		f.age_ms = '0; f.opening = '0; f.can_score = 1'b0;
		send_frame(f);
		f.rel_x = 15'h3FFF; f.rel_y = 15'h3FFF; f.ball_x = 14'h1FFF; f.ball_y = 14'h1FFF;
		f.robot_x = 14'h1FFF; f.robot_y = 14'h1FFF; f.heading = 16'h7FFF;
		send_frame(f);
		f = raw_frame();
		f.clear = 1'b1;
		send_frame(f);
	endtask

	// Streak builds to arming, saturates, drops on a failed hold, and clears.
	task automatic test_streaks();
		frame_t f;
		repeat (5) send_frame(ideal_frame());
		f = ideal_frame();
		f.rel_x = 15'sd420;  // inside hold, outside enter
		send_frame(f);
		f.age_ms = 16'd700;  // shoot hold fails, dribble holds
		send_frame(f);
		f.age_ms = 16'd2600;
		send_frame(f);
		repeat (2) send_frame(ideal_frame());
		f = ideal_frame();
		f.clear = 1'b1;
		send_frame(f);
		repeat (4) send_frame(ideal_frame());
		f = ideal_frame();
		f.heading = 16'sd7000;  // alignment between enter and hold limits
		f.can_score = 1'b0;
		f.opening = 15'd100;
		send_frame(f);
	endtask

	task automatic test_random_play(int n);
		repeat (n) send_frame(play_frame());
	endtask

	task automatic test_thresholds();
		write_threshold(CFG_UNUSED, 15'h7FFF);
		write_threshold(CFG_ENTER, 15'h7FFF);
		write_threshold(CFG_EXIT, 15'h7FFF);
		test_random_play(150);
		write_threshold(CFG_ENTER, 15'd20000);
		write_threshold(CFG_EXIT, 15'd8000);
		test_random_play(150);
		write_threshold(CFG_ENTER, 15'd0);
		write_threshold(CFG_EXIT, 15'd0);
	endtask

	// Receiver side: stall at the current rate.
	always @(posedge clk)
		m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (gate_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", m_tdata);
			end else begin
				result_t due;
				due = gate_results_due.pop_front();
				if (m_tdata[0] !== due.shoot_on || m_tdata[1] !== due.dribble_on
						|| m_tdata[3:2] !== due.shoot_progress) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: shoot %b/%b dribble %b/%b progress %0d/%0d",
							due.shoot_on, m_tdata[0], due.dribble_on, m_tdata[1],
							due.shoot_progress, m_tdata[3:2]);
				end
			end
		end
	end

	// Watchdog: cycles with no request moving on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		open_enter_thr = '0;
		open_exit_thr = '0;
		shoot_armed = 1'b0;
		dribble_armed = 1'b0;
		shoot_streak = '0;
		dribble_streak = '0;
		send_idle_pct = 13;
		recv_idle_pct = 82;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_streaks();
		test_random_play(120);
		test_thresholds();
		send_idle_pct = 82;
		recv_idle_pct = 13;
		test_random_play(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_play(200);
		wait_idle();

		if (mismatches == 0 && gate_results_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sdg_pkg.sv
hw/rtl/sdg_cordic.sv
hw/rtl/sdg_front.sv
hw/rtl/sdg_back.sv
hw/rtl/shoot_dribble_hysteresis_gate_top.sv
tb/shoot_dribble_hysteresis_gate_top_tb.sv
